>>> rtl/ott_pkg.sv
// ----------------------------------------------------------------------------
// Outstanding transaction tracker package
// Shared types, operation codes, entry states and register constants.
// ----------------------------------------------------------------------------
package ott_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_LOOK,
        ST_CHECK,
        ST_SWEEP,
        ST_TAIL
    } t_state;

    localparam logic [2:0] FUNC_BEGIN   = 3'd0;
    localparam logic [2:0] FUNC_ACK     = 3'd1;
    localparam logic [2:0] FUNC_CONFIRM = 3'd2;
    localparam logic [2:0] FUNC_POLL    = 3'd3;
    localparam logic [2:0] FUNC_FIND    = 3'd4;
    localparam logic [2:0] FUNC_LATEST  = 3'd5;

    localparam logic [2:0] SS_EMPTY     = 3'd0;
    localparam logic [2:0] SS_PENDING   = 3'd1;
    localparam logic [2:0] SS_ACKED     = 3'd2;
    localparam logic [2:0] SS_FAILED    = 3'd3;
    localparam logic [2:0] SS_CONFIRMED = 3'd4;
    localparam logic [2:0] SS_TIMEOUT   = 3'd5;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_OK_CODE = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
    localparam logic [7:0]  OK_CODE_RESET = 8'd0;
    localparam logic [15:0] SEQ_FIRST     = 16'd1;
    localparam logic [15:0] SEQ_LAST      = 16'hFFFF;

    typedef struct packed {
        logic [15:0] seq;
        logic [2:0]  state;
        logic [7:0]  floor;
        logic [7:0]  cmd;
        logic [7:0]  gpio;
        logic [7:0]  level;
        logic [7:0]  origin;
        logic [7:0]  code;
        logic [31:0] start;
        logic [31:0] update;
    } t_entry;

endpackage

>>> rtl/outstanding_transaction_tracker.sv
// ----------------------------------------------------------------------------
// Outstanding transaction tracker
// Begin and unknown operations give their result the cycle after start.
// Ack and find pass through a reciprocal multiply at start that gives the quotient,
// one remainder step that gives the slot, one read and one check.
// Confirm, poll and find-latest sweep every slot, one slot per cycle through
// the single read port of the slot memory.
// A new start is taken in the cycle the result strobe is high; results cannot stall.
// Reset: control, registers and per-slot valid bits clear at once; all slots read empty.
// ----------------------------------------------------------------------------
module outstanding_transaction_tracker #(
    parameter int SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_func,
    input  logic [7:0]  i_floor_num,
    input  logic [7:0]  i_cmd_kind,
    input  logic [7:0]  i_pin_idx,
    input  logic [7:0]  i_level,
    input  logic [7:0]  i_origin_tag,
    input  logic [15:0] i_seq_in,
    input  logic [7:0]  i_ack_code,
    input  logic [31:0] i_now_ms,
    output logic        o_done,
    output logic        o_hit,
    output logic [15:0] o_seq_out,
    output logic [2:0]  o_entry_state,
    output logic [7:0]  o_floor_out,
    output logic [7:0]  o_cmd_out,
    output logic [7:0]  o_gpio_out,
    output logic [7:0]  o_level_out,
    output logic [7:0]  o_origin_out,
    output logic [7:0]  o_code_out,
    output logic [31:0] o_start_out,
    output logic [31:0] o_update_out,
    output logic [15:0] o_latest_seq,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam int QSH = 16 + IW;
    localparam int RECIP_I = ((1 << QSH) + SLOTS - 1) / SLOTS;
    localparam logic [16:0] RECIP = 17'(RECIP_I);
    localparam logic [15:0] SLOTS_W = 16'(SLOTS);

    ott_pkg::t_state r_state, n_state;
    logic            r_done, n_done;
    logic [15:0]     r_next_seq, n_next_seq;
    logic [IW-1:0]   r_next_slot, n_next_slot;
    logic [15:0]     r_timeout;
    logic [7:0]      r_ok_code;

    logic [2:0]      r_func, n_func;
    logic [7:0]      r_floor, n_floor;
    logic [7:0]      r_cmd, n_cmd;
    logic [7:0]      r_gpio, n_gpio;
    logic [7:0]      r_level, n_level;
    logic [15:0]     r_seq_in, n_seq_in;
    logic [7:0]      r_ack, n_ack;
    logic [31:0]     r_now, n_now;

    logic [IW-1:0]   r_idx, n_idx;
    logic [15:0]     r_quo, n_quo;
    logic [IW-1:0]   r_rem, n_rem;
    logic [IW-1:0]   r_rd_idx, n_rd_idx;
    logic            r_rd_live, n_rd_live;
    logic            r_hit, n_hit;
    ott_pkg::t_entry r_best, n_best;
    ott_pkg::t_entry r_out, n_out;
    logic            r_out_hit, n_out_hit;

    ott_pkg::t_entry m_mem [SLOTS];
    logic [SLOTS-1:0] r_valid;
    ott_pkg::t_entry r_rd_data;
    logic            r_rd_valid;
    logic [IW-1:0]   rd_addr;
    logic            mem_we;
    logic [IW-1:0]   mem_waddr;
    ott_pkg::t_entry mem_wdata;

    ott_pkg::t_entry w_e;
    ott_pkg::t_entry w_new;
    ott_pkg::t_entry w_upd;
    logic [47:0]     w_prod;
    logic [15:0]     w_rem;
    logic [31:0]     w_age;
    logic            w_attr_match;
    logic            start_acc;
    logic            cfg_wr;

    assign busy      = (r_state != ott_pkg::ST_IDLE);
    assign start_acc = start && !busy;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr[2] == ott_pkg::REG_OK_CODE) ? {24'd0, r_ok_code}
                                                          : {16'd0, r_timeout};

    assign rd_addr = (r_state == ott_pkg::ST_SWEEP) ? r_idx : r_rem;
    assign w_e     = r_rd_valid ? r_rd_data : '0;
    assign w_prod  = {32'd0, i_seq_in} * {31'd0, RECIP};
    assign w_rem   = r_seq_in - r_quo * SLOTS_W;
    assign w_age   = r_now - w_e.start;
    assign w_attr_match = (w_e.floor == r_floor) && (w_e.cmd == r_cmd) &&
                          (w_e.gpio == r_gpio);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= m_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ott_pkg::ST_IDLE;
            r_done      <= 1'b0;
            r_next_seq  <= ott_pkg::SEQ_FIRST;
            r_next_slot <= IW'(1);
            r_timeout   <= ott_pkg::TIMEOUT_RESET;
            r_ok_code   <= ott_pkg::OK_CODE_RESET;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_next_seq  <= n_next_seq;
            r_next_slot <= n_next_slot;
            r_rd_valid  <= r_valid[rd_addr];
            r_rd_live   <= n_rd_live;
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            if (cfg_wr) begin
                if (paddr[2] == ott_pkg::REG_OK_CODE) begin
                    r_ok_code <= pwdata[7:0];
                end else begin
                    r_timeout <= pwdata[15:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_floor   <= n_floor;
        r_cmd     <= n_cmd;
        r_gpio    <= n_gpio;
        r_level   <= n_level;
        r_seq_in  <= n_seq_in;
        r_ack     <= n_ack;
        r_now     <= n_now;
        r_idx     <= n_idx;
        r_quo     <= n_quo;
        r_rem     <= n_rem;
        r_rd_idx  <= n_rd_idx;
        r_hit     <= n_hit;
        r_best    <= n_best;
        r_out     <= n_out;
        r_out_hit <= n_out_hit;
    end

    always_comb begin
        n_state     = r_state;
        n_done      = 1'b0;
        n_next_seq  = r_next_seq;
        n_next_slot = r_next_slot;
        n_func      = r_func;
        n_floor     = r_floor;
        n_cmd       = r_cmd;
        n_gpio      = r_gpio;
        n_level     = r_level;
        n_seq_in    = r_seq_in;
        n_ack       = r_ack;
        n_now       = r_now;
        n_idx       = r_idx;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_rd_idx    = r_rd_idx;
        n_rd_live   = 1'b0;
        n_hit       = r_hit;
        n_best      = r_best;
        n_out       = r_out;
        n_out_hit   = r_out_hit;
        mem_we      = 1'b0;
        mem_waddr   = r_rd_idx;
        mem_wdata   = w_e;

        w_new          = '0;
        w_new.seq      = r_next_seq;
        w_new.state    = ott_pkg::SS_PENDING;
        w_new.floor    = i_floor_num;
        w_new.cmd      = i_cmd_kind;
        w_new.gpio     = i_pin_idx;
        w_new.level    = i_level;
        w_new.origin   = i_origin_tag;
        w_new.start    = i_now_ms;
        w_new.update   = i_now_ms;

        w_upd = w_e;

        case (r_state)
            ott_pkg::ST_IDLE: begin
                if (start_acc) begin
                    n_func   = i_func;
                    n_floor  = i_floor_num;
                    n_cmd    = i_cmd_kind;
                    n_gpio   = i_pin_idx;
                    n_level  = i_level;
                    n_seq_in = i_seq_in;
                    n_ack    = i_ack_code;
                    n_now    = i_now_ms;
                    case (i_func)
                        ott_pkg::FUNC_BEGIN: begin
                            mem_we    = 1'b1;
                            mem_waddr = r_next_slot;
                            mem_wdata = w_new;
                            n_out     = w_new;
                            n_out_hit = 1'b1;
                            n_done    = 1'b1;
                            if (r_next_seq == ott_pkg::SEQ_LAST) begin
                                n_next_seq  = ott_pkg::SEQ_FIRST;
                                n_next_slot = IW'(1);
                            end else begin
                                n_next_seq  = r_next_seq + 16'd1;
                                n_next_slot = (r_next_slot == LAST_IDX) ? '0
                                                                        : r_next_slot + IW'(1);
                            end
                        end
                        ott_pkg::FUNC_ACK, ott_pkg::FUNC_FIND: begin
                            n_quo   = w_prod[QSH +: 16];
                            n_state = ott_pkg::ST_MOD;
                        end
                        ott_pkg::FUNC_CONFIRM, ott_pkg::FUNC_POLL,
                        ott_pkg::FUNC_LATEST: begin
                            n_idx   = '0;
                            n_hit   = 1'b0;
                            n_best  = '0;
                            n_state = ott_pkg::ST_SWEEP;
                        end
                        default: begin
                            n_out     = '0;
                            n_out_hit = 1'b0;
                            n_done    = 1'b1;
                        end
                    endcase
                end
            end
            ott_pkg::ST_MOD: begin
                n_rem   = w_rem[IW-1:0];
                n_state = ott_pkg::ST_LOOK;
            end
            ott_pkg::ST_LOOK: begin
                n_state = ott_pkg::ST_CHECK;
            end
            ott_pkg::ST_CHECK: begin
                n_state   = ott_pkg::ST_IDLE;
                n_done    = 1'b1;
                n_out     = '0;
                n_out_hit = 1'b0;
                if ((r_seq_in != 16'd0) && (w_e.seq == r_seq_in)) begin
                    n_out_hit = 1'b1;
                    if (r_func == ott_pkg::FUNC_ACK) begin
                        w_upd.state  = (r_ack == r_ok_code) ? ott_pkg::SS_ACKED
                                                            : ott_pkg::SS_FAILED;
                        w_upd.code   = r_ack;
                        w_upd.update = r_now;
                        mem_we       = 1'b1;
                        mem_waddr    = r_rem;
                        mem_wdata    = w_upd;
                        n_out        = w_upd;
                    end else begin
                        n_out = w_e;
                    end
                end
            end
            ott_pkg::ST_SWEEP, ott_pkg::ST_TAIL: begin
                if (r_state == ott_pkg::ST_SWEEP) begin
                    n_rd_live = 1'b1;
                    n_rd_idx  = r_idx;
                    if (r_idx == LAST_IDX) begin
                        n_state = ott_pkg::ST_TAIL;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
                if (r_rd_live) begin
                    case (r_func)
                        ott_pkg::FUNC_CONFIRM: begin
                            if ((w_e.state == ott_pkg::SS_ACKED) && w_attr_match &&
                                (w_e.level == r_level)) begin
                                w_upd.state  = ott_pkg::SS_CONFIRMED;
                                w_upd.update = r_now;
                                mem_we       = 1'b1;
                                mem_wdata    = w_upd;
                                n_hit        = 1'b1;
                            end
                        end
                        ott_pkg::FUNC_POLL: begin
                            if ((w_e.state == ott_pkg::SS_PENDING) &&
                                (w_age > {16'd0, r_timeout})) begin
                                w_upd.state  = ott_pkg::SS_TIMEOUT;
                                w_upd.update = r_now;
                                mem_we       = 1'b1;
                                mem_wdata    = w_upd;
                                n_hit        = 1'b1;
                            end
                        end
                        default: begin
                            if ((w_e.seq != 16'd0) && w_attr_match &&
                                (!r_hit || (w_e.seq > r_best.seq))) begin
                                n_best = w_e;
                                n_hit  = 1'b1;
                            end
                        end
                    endcase
                end
                if (r_state == ott_pkg::ST_TAIL) begin
                    n_state   = ott_pkg::ST_IDLE;
                    n_done    = 1'b1;
                    n_out_hit = n_hit;
                    n_out     = ((r_func == ott_pkg::FUNC_LATEST) && n_hit) ? n_best : '0;
                end
            end
            default: begin
                n_state = ott_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_done        = r_done;
    assign o_hit         = r_out_hit;
    assign o_seq_out     = r_out.seq;
    assign o_entry_state = r_out.state;
    assign o_floor_out   = r_out.floor;
    assign o_cmd_out     = r_out.cmd;
    assign o_gpio_out    = r_out.gpio;
    assign o_level_out   = r_out.level;
    assign o_origin_out  = r_out.origin;
    assign o_code_out    = r_out.code;
    assign o_start_out   = r_out.start;
    assign o_update_out  = r_out.update;
    assign o_latest_seq  = r_next_seq - 16'd1;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    a_fell_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("left busy without a result");

    a_seq_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_seq != 16'd0)
        else $error("next sequence is zero");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_seq_out == 16'd0 &&
                                o_entry_state == ott_pkg::SS_EMPTY))
        else $error("missed operation reports an entry");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start_acc && (i_func == ott_pkg::FUNC_ACK || i_func == ott_pkg::FUNC_FIND))
        |=> (busy && !o_done))
        else $error("lookup did not start its index search");

endmodule

>>> tb/tb_outstanding_transaction_tracker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Outstanding transaction tracker testbench
// Drives begin, ack, confirm, poll, find, find-latest and spare commands
// through the start/busy handshake and programs the timeout and success-code
// registers over APB between phases. A local model of the slot table predicts
// each result, and the monitor checks each done strobe field by field against
// it. The run is a short directed sequence, then random traffic under several
// register settings.
// ----------------------------------------------------------------------------
module tb_outstanding_transaction_tracker;

    localparam int SLOTS = 32;
    localparam int RING  = 64;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS  = 385;

    localparam logic [2:0] FUNC_SPARE_A = 3'd6;
    localparam logic [2:0] FUNC_SPARE_B = 3'd7;

    typedef struct packed {
        logic [2:0]  func;
        logic [7:0]  floor_num;
        logic [7:0]  cmd_kind;
        logic [7:0]  pin_idx;
        logic [7:0]  level;
        logic [7:0]  origin_tag;
        logic [15:0] seq_in;
        logic [7:0]  ack_code;
        logic [31:0] now_ms;
    } t_cmd;

    typedef struct packed {
        logic            hit;
        ott_pkg::t_entry ent;
        logic [15:0]     latest;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_cmd        cur_cmd = '0;
    logic        o_done;
    logic        o_hit;
    logic [15:0] o_seq_out;
    logic [2:0]  o_entry_state;
    logic [7:0]  o_floor_out;
    logic [7:0]  o_cmd_out;
    logic [7:0]  o_gpio_out;
    logic [7:0]  o_level_out;
    logic [7:0]  o_origin_out;
    logic [7:0]  o_code_out;
    logic [31:0] o_start_out;
    logic [31:0] o_update_out;
    logic [15:0] o_latest_seq;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // model state
    ott_pkg::t_entry slot_tab [SLOTS];
    logic [15:0] seq_next = ott_pkg::SEQ_FIRST;
    logic [15:0] cfg_timeout = ott_pkg::TIMEOUT_RESET;
    logic [7:0]  cfg_ok = ott_pkg::OK_CODE_RESET;

    // stimulus state
    t_cmd        cmd_q [$];
    t_outcome    outcome_q [$];
    t_cmd        recent [RING];
    logic [15:0] recent_seq [RING];
    int          recent_n = 0;
    logic [15:0] gen_seq = ott_pkg::SEQ_FIRST;
    logic [31:0] clock_ms = '0;
    logic        xfer_taken = 1'b0;
    int          gap_left = 0;
    int          quiet_left = 0;
    int          err_cnt = 0;

    outstanding_transaction_tracker #(
        .SLOTS(SLOTS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (cur_cmd.func),
        .i_floor_num  (cur_cmd.floor_num),
        .i_cmd_kind   (cur_cmd.cmd_kind),
        .i_pin_idx    (cur_cmd.pin_idx),
        .i_level      (cur_cmd.level),
        .i_origin_tag (cur_cmd.origin_tag),
        .i_seq_in     (cur_cmd.seq_in),
        .i_ack_code   (cur_cmd.ack_code),
        .i_now_ms     (cur_cmd.now_ms),
        .o_done       (o_done),
        .o_hit        (o_hit),
        .o_seq_out    (o_seq_out),
        .o_entry_state(o_entry_state),
        .o_floor_out  (o_floor_out),
        .o_cmd_out    (o_cmd_out),
        .o_gpio_out   (o_gpio_out),
        .o_level_out  (o_level_out),
        .o_origin_out (o_origin_out),
        .o_code_out   (o_code_out),
        .o_start_out  (o_start_out),
        .o_update_out (o_update_out),
        .o_latest_seq (o_latest_seq),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_outcome track_step(t_cmd c);
        t_outcome    r;
        int          idx;
        int          best;
        logic [15:0] s;
        logic [31:0] age;
        r = '0;
        best = 0;
        case (c.func)
            ott_pkg::FUNC_BEGIN: begin
                s = seq_next;
                seq_next = seq_next + 16'd1;
                if (seq_next == '0) begin
                    seq_next = ott_pkg::SEQ_FIRST;
                end
                idx = s % SLOTS;
                slot_tab[idx].seq      = s;
                slot_tab[idx].state    = ott_pkg::SS_PENDING;
                slot_tab[idx].floor    = c.floor_num;
                slot_tab[idx].cmd      = c.cmd_kind;
                slot_tab[idx].gpio     = c.pin_idx;
                slot_tab[idx].level    = c.level;
                slot_tab[idx].origin   = c.origin_tag;
                slot_tab[idx].code     = '0;
                slot_tab[idx].start    = c.now_ms;
                slot_tab[idx].update   = c.now_ms;
                r.hit = 1'b1;
                r.ent = slot_tab[idx];
            end
            ott_pkg::FUNC_ACK: begin
                idx = c.seq_in % SLOTS;
                if (c.seq_in != '0 && slot_tab[idx].seq == c.seq_in) begin
                    slot_tab[idx].state  = (c.ack_code == cfg_ok) ? ott_pkg::SS_ACKED
                                                                  : ott_pkg::SS_FAILED;
                    slot_tab[idx].code   = c.ack_code;
                    slot_tab[idx].update = c.now_ms;
                    r.hit = 1'b1;
                    r.ent = slot_tab[idx];
                end
            end
            ott_pkg::FUNC_CONFIRM: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_tab[i].state == ott_pkg::SS_ACKED &&
                        slot_tab[i].floor == c.floor_num &&
                        slot_tab[i].cmd == c.cmd_kind && slot_tab[i].gpio == c.pin_idx &&
                        slot_tab[i].level == c.level) begin
                        slot_tab[i].state  = ott_pkg::SS_CONFIRMED;
                        slot_tab[i].update = c.now_ms;
                        r.hit = 1'b1;
                    end
                end
            end
            ott_pkg::FUNC_POLL: begin
                for (int i = 0; i < SLOTS; i++) begin
                    age = c.now_ms - slot_tab[i].start;
                    if (slot_tab[i].state == ott_pkg::SS_PENDING &&
                        age > {16'b0, cfg_timeout}) begin
                        slot_tab[i].state  = ott_pkg::SS_TIMEOUT;
                        slot_tab[i].update = c.now_ms;
                        r.hit = 1'b1;
                    end
                end
            end
            ott_pkg::FUNC_FIND: begin
                idx = c.seq_in % SLOTS;
                if (c.seq_in != '0 && slot_tab[idx].seq == c.seq_in) begin
                    r.hit = 1'b1;
                    r.ent = slot_tab[idx];
                end
            end
            ott_pkg::FUNC_LATEST: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_tab[i].seq != '0 && slot_tab[i].floor == c.floor_num &&
                        slot_tab[i].cmd == c.cmd_kind && slot_tab[i].gpio == c.pin_idx) begin
                        if (!r.hit || slot_tab[i].seq > slot_tab[best].seq) begin
                            best = i;
                            r.hit = 1'b1;
                        end
                    end
                end
                if (r.hit) begin
                    r.ent = slot_tab[best];
                end
            end
            default: begin
            end
        endcase
        r.latest = (seq_next > ott_pkg::SEQ_FIRST) ? seq_next - ott_pkg::SEQ_FIRST : '0;
        return r;
    endfunction

    task automatic check_field(string nm, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s expected %0h actual %0h", $time, nm, want, got);
        end
    endtask

    // check results, then log the transfer taken at this edge
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n) begin
            if (o_done) begin
                got.hit    = o_hit;
                got.ent    = {o_seq_out, o_entry_state, o_floor_out, o_cmd_out, o_gpio_out,
                              o_level_out, o_origin_out, o_code_out, o_start_out, o_update_out};
                got.latest = o_latest_seq;
                if (outcome_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result expected none actual seq %0h", $time, o_seq_out);
                end else begin
                    want = outcome_q.pop_front();
                    check_field("hit", want.hit, got.hit);
                    check_field("seq_out", want.ent.seq, got.ent.seq);
                    check_field("entry_state", want.ent.state, got.ent.state);
                    check_field("floor_out", want.ent.floor, got.ent.floor);
                    check_field("cmd_out", want.ent.cmd, got.ent.cmd);
                    check_field("gpio_out", want.ent.gpio, got.ent.gpio);
                    check_field("level_out", want.ent.level, got.ent.level);
                    check_field("origin_out", want.ent.origin, got.ent.origin);
                    check_field("code_out", want.ent.code, got.ent.code);
                    check_field("start_out", want.ent.start, got.ent.start);
                    check_field("update_out", want.ent.update, got.ent.update);
                    check_field("latest_seq", want.latest, got.latest);
                end
            end
            if (start && !busy) begin
                outcome_q.push_back(track_step(cur_cmd));
                xfer_taken = 1'b1;
            end
        end
    end

    // present commands from the queue, with a random gap before each one
    always @(negedge i_clk) begin
        logic go;
        go = start && !xfer_taken;
        if (xfer_taken) begin
            xfer_taken = 1'b0;
            if (quiet_left > 0) begin
                gap_left = 0;
                quiet_left--;
            end else begin
                gap_left = $urandom_range(0, 19);
                if ($urandom_range(0, 15) == 0) begin
                    quiet_left = $urandom_range(8, 40);
                end
            end
        end
        if (!go && i_rst_n) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (cmd_q.size() > 0) begin
                cur_cmd <= cmd_q.pop_front();
                go = 1'b1;
            end
        end
        start <= go;
    end

    function automatic void push_cmd(t_cmd c);
        if (c.func == ott_pkg::FUNC_BEGIN) begin
            recent[recent_n % RING]     = c;
            recent_seq[recent_n % RING] = gen_seq;
            recent_n++;
            gen_seq = gen_seq + 16'd1;
            if (gen_seq == '0) begin
                gen_seq = ott_pkg::SEQ_FIRST;
            end
        end
        cmd_q.push_back(c);
    endfunction

    function automatic t_cmd mk(logic [2:0] f, logic [7:0] fl, logic [7:0] cm, logic [7:0] gp,
                                logic [7:0] lv, logic [15:0] sq, logic [7:0] ack,
                                logic [31:0] now);
        t_cmd c;
        c.func = f;
        c.floor_num = fl;
        c.cmd_kind = cm;
        c.pin_idx = gp;
        c.level = lv;
        c.origin_tag = fl;
        c.seq_in = sq;
        c.ack_code = ack;
        c.now_ms = now;
        return c;
    endfunction

    // mostly a small pool so that confirm and find-latest match often
    function automatic logic [7:0] pick_attr();
        if ($urandom_range(0, 9) < 7) begin
            return 8'($urandom_range(0, 3));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic t_cmd rand_fields();
        t_cmd c;
        clock_ms = clock_ms + $urandom_range(0, 1200);
        if ($urandom_range(0, 49) == 0) begin
            clock_ms = $urandom();
        end
        c.func = ott_pkg::FUNC_BEGIN;
        c.floor_num = pick_attr();
        c.cmd_kind = pick_attr();
        c.pin_idx = pick_attr();
        c.level = pick_attr();
        c.origin_tag = 8'($urandom());
        c.seq_in = 16'($urandom());
        c.ack_code = 8'($urandom());
        c.now_ms = clock_ms;
        return c;
    endfunction

    function automatic void push_random();
        t_cmd c;
        int   span;
        int   k;
        int   r;
        c = rand_fields();
        span = (recent_n < RING) ? recent_n : RING;
        k = (recent_n - 1 - int'($urandom_range(0, span - 1))) % RING;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            c.func = ott_pkg::FUNC_BEGIN;
        end else if (r < 52) begin
            c.func = ott_pkg::FUNC_ACK;
            if (r < 48) begin
                c.seq_in = recent_seq[k];
            end else if (r < 50) begin
                c.seq_in = '0;
            end
            if ($urandom_range(0, 9) < 6) begin
                c.ack_code = cfg_ok;
            end
        end else if (r < 64) begin
            c.func = ott_pkg::FUNC_CONFIRM;
            if (r < 61) begin
                c.floor_num = recent[k].floor_num;
                c.cmd_kind = recent[k].cmd_kind;
                c.pin_idx = recent[k].pin_idx;
                c.level = recent[k].level;
            end
        end else if (r < 76) begin
            c.func = ott_pkg::FUNC_POLL;
            if (r < 70) begin
                c.now_ms = recent[k].now_ms + {16'b0, cfg_timeout} + $urandom_range(0, 1);
            end
        end else if (r < 88) begin
            c.func = ott_pkg::FUNC_FIND;
            if (r < 85) begin
                c.seq_in = recent_seq[k];
            end else if (r < 86) begin
                c.seq_in = '0;
            end
        end else if (r < 97) begin
            c.func = ott_pkg::FUNC_LATEST;
            if (r < 95) begin
                c.floor_num = recent[k].floor_num;
                c.cmd_kind = recent[k].cmd_kind;
                c.pin_idx = recent[k].pin_idx;
            end
        end else begin
            c.func = (r < 99) ? FUNC_SPARE_A : FUNC_SPARE_B;
        end
        push_cmd(c);
    endfunction

    task automatic wait_drained();
        while (cmd_q.size() > 0 || start || outcome_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic sel, logic [31:0] val);
        logic [31:0] want;
        want = (sel == ott_pkg::REG_TIMEOUT) ? {16'b0, val[15:0]} : {24'b0, val[7:0]};
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == ott_pkg::REG_TIMEOUT) begin
            cfg_timeout = val[15:0];
        end else begin
            cfg_ok = val[7:0];
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (sel == ott_pkg::REG_TIMEOUT) begin
            check_field("timeout_ms", want, {16'b0, prdata[15:0]});
        end else begin
            check_field("ok_result_code", want, {24'b0, prdata[7:0]});
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        logic [15:0] tmo_set [5];
        logic [7:0]  ok_set [5];
        foreach (slot_tab[i]) begin
            slot_tab[i] = '0;
        end
        tmo_set = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(1, 65535)),
                    ott_pkg::TIMEOUT_RESET};
        ok_set  = '{8'hFF, 8'h00, 8'($urandom()), 8'($urandom()), ott_pkg::OK_CODE_RESET};
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, sequence zero
        push_cmd(mk(ott_pkg::FUNC_FIND, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_LATEST, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd0));
        // field extremes
        push_cmd(mk(ott_pkg::FUNC_BEGIN, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_BEGIN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF,
                    32'hFFFF_FFFF));
        push_cmd(mk(ott_pkg::FUNC_FIND, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_FIND, 8'd0, 8'd0, 8'd0, 8'd0, 16'd2, 8'd0, 32'd0));
        // ack success, failure, then re-ack of a failed entry
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd0, 32'd10));
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd2, 8'hFF, 32'd20));
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd2, 8'd0, 32'd30));
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd33, 8'd0, 32'd35));
        push_cmd(mk(ott_pkg::FUNC_CONFIRM, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd40));
        push_cmd(mk(ott_pkg::FUNC_CONFIRM, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0, 8'd0, 32'd50));
        // poll across the 32-bit time wrap and at the age boundary
        push_cmd(mk(ott_pkg::FUNC_BEGIN, 8'd1, 8'd2, 8'd3, 8'd4, 16'd0, 8'd0, 32'hFFFF_F000));
        push_cmd(mk(ott_pkg::FUNC_BEGIN, 8'd1, 8'd2, 8'd3, 8'd4, 16'd0, 8'd0, 32'd100));
        push_cmd(mk(ott_pkg::FUNC_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd3100));
        push_cmd(mk(ott_pkg::FUNC_POLL, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 8'd0, 32'd3101));
        push_cmd(mk(ott_pkg::FUNC_LATEST, 8'd1, 8'd2, 8'd3, 8'd0, 16'd0, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_LATEST, 8'hFF, 8'hFF, 8'hFF, 8'd0, 16'd0, 8'd0, 32'd0));
        push_cmd(mk(FUNC_SPARE_A, 8'd0, 8'd0, 8'd0, 8'd0, 16'd1, 8'd0, 32'd0));
        push_cmd(mk(FUNC_SPARE_B, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd2, 8'hFF, 32'hFFFF_FFFF));
        push_cmd(mk(ott_pkg::FUNC_FIND, 8'd0, 8'd0, 8'd0, 8'd0, 16'hFFFF, 8'd0, 32'd0));
        push_cmd(mk(ott_pkg::FUNC_ACK, 8'd0, 8'd0, 8'd0, 8'd0, 16'd4, 8'd7, 32'd3200));
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            write_reg(ott_pkg::REG_TIMEOUT, {16'b0, tmo_set[p]});
            write_reg(ott_pkg::REG_OK_CODE, {24'b0, ok_set[p]});
            repeat (PHASE_ITEMS) push_random();
            wait_drained();
        end

        if (err_cnt == 0) begin
            $display("tb_outstanding_transaction_tracker: clean");
        end else begin
            $display("tb_outstanding_transaction_tracker: errors");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_outstanding_transaction_tracker: errors");
        $finish;
    end

endmodule
